// ===== rtl/nsr_pkg.sv =====
// Shared types and constants for the Newton square root block.
package nsr_pkg;

   // Width of the iteration-limit register.
   localparam int LIMIT_BITS = 6;

   // Iteration limit after reset (five Newton steps).
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 6'd4;

   // Sequencer states.
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_DIVIDE,
      SEQ_UPDATE,
      SEQ_FINISH
   } seq_state_type;

   // Controller to divider.
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   // Divider to controller.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== rtl/nsr_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by all Newton steps.
module nsr_divider
   import nsr_pkg::*;
#(
   parameter int WIDTH = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  div_ctrl_type         ctrl,
   input  logic [WIDTH-1:0]     dividend,
   input  logic [WIDTH-1:0]     divisor,
   output div_status_type       status,
   output logic [WIDTH-1:0]     quotient
);

   localparam int CNT_BITS = $clog2(WIDTH + 1);

   logic [WIDTH-1:0]    num_ff, num_in;   // dividend bits out, quotient bits in
   logic [WIDTH-1:0]    rem_ff, rem_in;
   logic [WIDTH-1:0]    den_ff, den_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;

   logic [WIDTH:0] trial;
   logic [WIDTH:0] diff;

   assign trial = {rem_ff, num_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      count_in = count_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (ctrl.start) begin
         num_in   = dividend;
         rem_in   = '0;
         den_in   = divisor;
         count_in = CNT_BITS'(WIDTH);
         run_in   = 1'b1;
      end else if (run_ff) begin
         // borrow clear means trial >= divisor
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
            num_in = {num_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[WIDTH-1:0];
            num_in = {num_ff[WIDTH-2:0], 1'b0};
         end
         count_in = count_ff - CNT_BITS'(1);
         if (count_ff == CNT_BITS'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         run_ff   <= run_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign status.busy = run_ff;
   assign status.done = done_ff;
   assign quotient    = num_ff;

endmodule

// ===== rtl/newton_square_root.sv =====
// Top level: Newton-Raphson square root of an unsigned fixed-point value.
// A zero radicand skips the divides and goes straight to the result stage.
// Throughput: one request at a time; the shared bit-serial divider sets the pace.
// Reset (synchronous, active high) idles the sequencer, drops rsp_tvalid and
//   sets the iteration limit to 4 (five Newton steps).
module newton_square_root
   import nsr_pkg::*;
#(
   parameter int VALUE_BITS = 24,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((VALUE_BITS+7)/8)*8-1:0]     req_tdata,   // [VALUE_BITS-1:0] radicand
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((VALUE_BITS+7)/8)*8-1:0]     rsp_tdata,   // [VALUE_BITS-1:0] root_estimate
   // iteration limit register
   input  logic                                csr_wr_en,
   input  logic [LIMIT_BITS-1:0]               csr_wr_data  // iteration_limit
);

   localparam int DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
   // Working width: the scaled dividend x << FRAC_BITS, also the estimate width.
   localparam int QW = VALUE_BITS + FRAC_BITS;
   // Quotient clamp; only reachable for very wide configurations.
   localparam logic [QW-1:0] QUOT_CAP = (QW > 62) ? (QW'(1) << 62) : '1;
   localparam logic [QW-1:0] VALUE_MAX = QW'({VALUE_BITS{1'b1}});

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   seq_state_type            state_ff, state_in;
   logic [LIMIT_BITS-1:0]    limit_ff, limit_in;       // programmed iteration limit
   logic [LIMIT_BITS-1:0]    steps_left_ff, steps_left_in; // Newton steps after current
   logic [VALUE_BITS-1:0]    radicand_ff, radicand_in; // latched x
   logic [QW-1:0]            estimate_ff, estimate_in; // running y
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]    rsp_data_ff, rsp_data_in;

   div_ctrl_type             div_ctrl;
   div_status_type           div_status;
   logic [QW-1:0]            div_quotient;

   logic                     req_accept;
   logic                     rsp_free;
   logic [VALUE_BITS-1:0]    req_radicand;
   logic [QW-1:0]            quot_capped;
   logic [QW:0]              step_sum;
   logic [QW-1:0]            step_next;
   logic [VALUE_BITS-1:0]    final_value;

   assign req_radicand = req_tdata[VALUE_BITS-1:0];
   assign req_tready   = (state_ff == SEQ_IDLE);
   assign req_accept   = req_tvalid && req_tready;
   // the output register can take a new result this cycle
   assign rsp_free     = !rsp_valid_ff || rsp_tready;

   // Newton update: y' = (y + min(q, cap)) >> 1
   assign quot_capped = (div_quotient > QUOT_CAP) ? QUOT_CAP : div_quotient;
   assign step_sum    = {1'b0, estimate_ff} + {1'b0, quot_capped};
   assign step_next   = step_sum[QW:1];

   // Result clamp to the output format
   assign final_value = (estimate_ff > VALUE_MAX) ? {VALUE_BITS{1'b1}}
                                                  : estimate_ff[VALUE_BITS-1:0];

   // ------------------------------------------------------------------
   // Shared divider: floor((x << FRAC_BITS) / y)
   // Operands come from the next-value side, since the divider latches
   // them on the same edge that loads x and the new y.
   // ------------------------------------------------------------------
   nsr_divider #(
      .WIDTH (QW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend ({radicand_in, {FRAC_BITS{1'b0}}}),
      .divisor  (estimate_in),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // ------------------------------------------------------------------
   // Sequencer: next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_accept) begin
               // zero radicand skips the divides entirely
               state_in = (req_radicand == '0) ? SEQ_FINISH : SEQ_DIVIDE;
            end
         end
         SEQ_DIVIDE: begin
            if (div_status.done) begin
               state_in = SEQ_UPDATE;
            end
         end
         SEQ_UPDATE: begin
            // stop after the last step, or if the estimate collapsed to zero
            if (steps_left_ff == '0 || step_next == '0) begin
               state_in = SEQ_FINISH;
            end else begin
               state_in = SEQ_DIVIDE;
            end
         end
         SEQ_FINISH: begin
            if (rsp_free) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer: datapath controls
   // ------------------------------------------------------------------
   always_comb begin
      limit_in       = limit_ff;
      steps_left_in  = steps_left_ff;
      radicand_in    = radicand_ff;
      estimate_in    = estimate_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      div_ctrl.start = 1'b0;

      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end

      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_accept) begin
               radicand_in    = req_radicand;
               estimate_in    = QW'(req_radicand);   // first guess y = x
               steps_left_in  = limit_ff;
               div_ctrl.start = (req_radicand != '0);
            end
         end
         SEQ_DIVIDE: begin
         end
         SEQ_UPDATE: begin
            estimate_in = step_next;
            if (steps_left_ff != '0 && step_next != '0) begin
               steps_left_in  = steps_left_ff - LIMIT_BITS'(1);
               div_ctrl.start = 1'b1;
            end
         end
         SEQ_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = final_value;
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         limit_ff      <= LIMIT_RESET;
         steps_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         limit_ff      <= limit_in;
         steps_left_ff <= steps_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      radicand_ff <= radicand_in;
      estimate_ff <= estimate_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'(rsp_data_ff);

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // divider only finishes while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == SEQ_DIVIDE)
      else $error("divider done outside divide state");

   // the divider is never restarted while it is still running
   assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> !div_status.busy)
      else $error("divider restarted while busy");

   // a zero radicand goes straight to the result stage
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_radicand == '0 |=> state_ff == SEQ_FINISH)
      else $error("zero radicand not short-circuited");

   // a finished item never overwrites a result still waiting
   assert property (@(posedge clock) disable iff (reset)
      state_ff == SEQ_FINISH && rsp_valid_ff && !rsp_tready |=> state_ff == SEQ_FINISH)
      else $error("result stage left while output stalled");

endmodule

// ===== tb/root_monitor.sv =====
// Monitor for the Newton square root block: predicts each root and checks every response.
module root_monitor
   import nsr_pkg::*;
#(
   parameter int VALUE_BITS = 24,
   parameter int FRAC_BITS  = 16,
   parameter int DATA_W     = ((VALUE_BITS+7)/8)*8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,    // [VALUE_BITS-1:0] radicand
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [DATA_W-1:0]     rsp_tdata,    // [VALUE_BITS-1:0] root_estimate
   input  logic                  csr_wr_en,
   input  logic [LIMIT_BITS-1:0] csr_wr_data,  // iteration_limit
   output int                    open_count,
   output int                    mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] ROOT_MAX     = (64'd1 << VALUE_BITS) - 1;
   localparam logic [63:0] QUOTIENT_CAP = 64'd1 << 62;

   typedef struct {
      logic [VALUE_BITS-1:0] radicand;
      logic [VALUE_BITS-1:0] root;
   } root_expectation_type;

   root_expectation_type  expected_roots[$];
   logic [LIMIT_BITS-1:0] iter_limit = LIMIT_RESET;

   // Fixed-point Newton iteration from y = x, limit+1 steps.
   function automatic logic [VALUE_BITS-1:0] newton_root(input logic [VALUE_BITS-1:0] x,
                                                         input logic [LIMIT_BITS-1:0] limit);
      logic [63:0] y;
      logic [63:0] quotient;
      int          n;
      if (x == '0)
         return '0;
      y = 64'(x);
      for (n = 0; n <= int'(limit); n++) begin
         if (y == 0)
            break;
         quotient = (64'(x) << FRAC_BITS) / y;
         if (quotient > QUOTIENT_CAP)
            quotient = QUOTIENT_CAP;
         y = (y + quotient) >> 1;
      end
      if (y > ROOT_MAX)
         y = ROOT_MAX;
      return y[VALUE_BITS-1:0];
   endfunction

   always @(posedge clock) begin
      root_expectation_type exp_root;
      if (reset) begin
         iter_limit = LIMIT_RESET;
         expected_roots.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_roots.size() == 0) begin
               $display("%t: unexpected response, root %h", $time, rsp_tdata[VALUE_BITS-1:0]);
               mismatch_count++;
            end else begin
               exp_root = expected_roots.pop_front();
               if (rsp_tdata[VALUE_BITS-1:0] !== exp_root.root) begin
                  $display("%t: root mismatch for radicand %h: expected %h, actual %h",
                           $time, exp_root.radicand, exp_root.root,
                           rsp_tdata[VALUE_BITS-1:0]);
                  mismatch_count++;
               end
            end
         end
         // prediction uses the limit in force before any write at this edge
         if (req_tvalid && req_tready)
            expected_roots.push_back('{req_tdata[VALUE_BITS-1:0],
                                       newton_root(req_tdata[VALUE_BITS-1:0], iter_limit)});
         if (csr_wr_en)
            iter_limit = csr_wr_data;
      end
      open_count <= expected_roots.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the Newton square root block: stimulus, handshake pacing and verdict.
module tb_top
   import nsr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD = 8;
   localparam int DATA_W       = 24;
   localparam int ITEM_TARGET  = 950;
   // watchdog bound, far above the worst planned run including stalls
   localparam int CYCLE_LIMIT  = 2_000_000;
   // receiver hold-off: far longer than one request at a small limit
   localparam int HOLD_CYCLES  = 700;
   localparam int HOLD_AT      = 150;
   // tail wait, longer than one result at the largest limit used in the closing phases
   localparam int TAIL_CYCLES  = 400;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata   = '0;   // [23:0] radicand
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;          // [23:0] root_estimate
   logic                  csr_wr_en   = 1'b0;
   logic [LIMIT_BITS-1:0] csr_wr_data = '0;   // iteration_limit

   int open_count;
   int mismatch_count;
   int requests_sent = 0;

   always #(CLOCK_PERIOD/2) clock = ~clock;

   newton_square_root uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   root_monitor root_mon (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .open_count     (open_count),
      .mismatch_count (mismatch_count)
   );

   // Pacing by progress: first third slow sender / very slow receiver,
   // second third the reverse, last third full rate on both sides.
   function automatic int sender_idle_pct();
      if (requests_sent < ITEM_TARGET/3)
         return 34;
      else if (requests_sent < 2*ITEM_TARGET/3)
         return 72;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (requests_sent < ITEM_TARGET/3)
         return 72;
      else if (requests_sent < 2*ITEM_TARGET/3)
         return 34;
      return 0;
   endfunction

   // Radicand mix: full range, tiny values, exact squares, single bits, near full scale, zero.
   function automatic logic [DATA_W-1:0] pick_radicand();
      int unsigned  pick;
      logic [11:0]  k;
      pick = $urandom_range(99);
      k    = 12'($urandom);
      if (pick < 40)
         return 24'($urandom);
      else if (pick < 60)
         return 24'($urandom_range(255));
      else if (pick < 72)
         return 24'(k) * 24'(k);           // exact square: true root is k, k << 8 in the output format
      else if (pick < 82)
         return 24'd1 << $urandom_range(23);
      else if (pick < 94)
         return 24'hFFFFFF - 24'($urandom_range(255));
      return '0;
   endfunction

   // Offer one request; tvalid stays high afterwards, so back-to-back requests keep it
   // up unless a random sender idle drops it. The caller lowers it at phase ends.
   task automatic offer_radicand(input logic [DATA_W-1:0] x);
      while ($urandom_range(99) < sender_idle_pct()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      requests_sent++;
   endtask

   // Let every outstanding request come back. open_count is registered, so the
   // initial clock wait also covers a request accepted just now.
   task automatic drain_requests();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_count != 0)
         @(posedge clock);
   endtask

   // Iteration limit is only changed with the block idle.
   task automatic set_iteration_limit(input logic [LIMIT_BITS-1:0] limit);
      drain_requests();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Receiver: random backpressure, plus one long hold-off in the
   // limit-0 phase while the sender keeps offering, so the block
   // sits on a finished root and stops taking requests.
   initial begin : receiver
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && requests_sent >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_idle_pct());
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      logic [DATA_W-1:0] corners[$];
      corners = '{24'h000000, 24'h000001, 24'h000002, 24'h000003, 24'hFFFFFF,
                  24'hFFFFFE, 24'h800000, 24'h7FFFFF, 24'h010000, 24'h040000,
                  24'h090000, 24'hE10000, 24'h004000, 24'h00FFFF, 24'hAAAAAA,
                  24'h555555, 24'h000100, 24'h123456, 24'h000000};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset limit (five steps): corners of the radicand, zero included
      foreach (corners[i])
         offer_radicand(corners[i]);

      // single step: fast turnaround, long hold-off lands here
      set_iteration_limit('0);
      repeat (150)
         offer_radicand(pick_radicand());

      // largest limit: slow, so only a few requests
      set_iteration_limit('1);
      offer_radicand(24'h000000);
      offer_radicand(24'hFFFFFF);
      offer_radicand(24'h000001);
      repeat (9)
         offer_radicand(pick_radicand());

      // mid-range limits keep the run short
      while (requests_sent < ITEM_TARGET) begin
         set_iteration_limit(LIMIT_BITS'($urandom_range(1, 7)));
         repeat (80)
            offer_radicand(pick_radicand());
      end

      drain_requests();
      // catch any stray response after the last expected one
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && open_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== newton_square_root.f =====
rtl/nsr_pkg.sv
rtl/nsr_divider.sv
rtl/newton_square_root.sv
tb/root_monitor.sv
tb/tb_top.sv
